// File: sv/ppct_pkg.sv
`default_nettype none
package ppct_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DVDR_W     = 43;
	localparam int NEG_W      = 42;
	localparam int DVDV_W     = 50;
	localparam int DRDR_W     = 33;
	localparam int SIG2_W     = 32;
	localparam int ROOT_W     = 43;
	localparam int DISC_W     = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int QUO_W      = 33;
	localparam int M_W        = NEG_W + 1 + FRAC_BITS;
	localparam int DREM_W     = DVDV_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [15:0]        x;
		logic [15:0]        y;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic [14:0]        r;
	} disc_t;

	// one classified pair between front and back
	typedef struct packed {
		logic                      kill;
		logic signed [DVDR_W-1:0]  dvdr;
		logic [DVDV_W-1:0]         dvdv;
		logic [DRDR_W-1:0]         drdr;
		logic [SIG2_W-1:0]         sig2;
		disc_t                     p1;
		disc_t                     p2;
	} geom_t;

	typedef struct packed {
		logic              kill;
		logic [NEG_W-1:0]  neg;
		logic [DVDV_W-1:0] dvdv;
		disc_t             p1;
		disc_t             p2;
	} ctx_t;

endpackage
`default_nettype wire

// File: sv/ppct_in_if.sv
`default_nettype none
interface ppct_in_if;
	logic               valid;
	logic               ready;
	logic               same_particle;
	logic [15:0]        first_x;
	logic [15:0]        first_y;
	logic signed [23:0] first_vx;
	logic signed [23:0] first_vy;
	logic [14:0]        first_radius;
	logic [15:0]        second_x;
	logic [15:0]        second_y;
	logic signed [23:0] second_vx;
	logic signed [23:0] second_vy;
	logic [14:0]        second_radius;

	modport source (output valid, same_particle, first_x, first_y, first_vx, first_vy,
		first_radius, second_x, second_y, second_vx, second_vy, second_radius,
		input ready);
	modport sink (input valid, same_particle, first_x, first_y, first_vx, first_vy,
		first_radius, second_x, second_y, second_vx, second_vy, second_radius,
		output ready);
endinterface
`default_nettype wire

// File: sv/ppct_out_if.sv
`default_nettype none
interface ppct_out_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] time_to_contact;

	modport source (output valid, hit, time_to_contact, input ready);
	modport sink (input valid, hit, time_to_contact, output ready);
endinterface
`default_nettype wire

// File: sv/ppct_front.sv
`default_nettype none
module ppct_front import ppct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	ppct_in_if.sink req,
	output geom_t push_data,
	output logic  push_valid,
	input  logic  push_ready
);

	logic adv;
	logic v_s1, v_s2, v_s3;

	disc_t              a_c, b_c;
	logic signed [16:0] dx_c, dy_c;
	logic signed [24:0] dvx_c, dvy_c;
	logic [15:0]        rs_c;

	logic               same_s1;
	disc_t              p1_s1, p2_s1;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [24:0] dvx_s1, dvy_s1;
	logic [15:0]        rs_s1;

	logic signed [41:0] dxv_c, dyv_c;
	logic signed [49:0] vxx_c, vyy_c;
	logic signed [33:0] dxx_c, dyy_c;
	logic [31:0]        rr_c;

	logic               same_s2;
	disc_t              p1_s2, p2_s2;
	logic signed [41:0] dxv_s2, dyv_s2;
	logic signed [49:0] vxx_s2, vyy_s2;
	logic signed [33:0] dxx_s2, dyy_s2;
	logic [31:0]        rr_s2;

	geom_t g_c, g_s3;

	assign adv        = !v_s3 || push_ready;
	assign req.ready  = adv;
	assign push_valid = v_s3;
	assign push_data  = g_s3;

	always_comb begin
		a_c = '{x: req.first_x, y: req.first_y, vx: req.first_vx, vy: req.first_vy,
			r: req.first_radius};
		b_c = '{x: req.second_x, y: req.second_y, vx: req.second_vx, vy: req.second_vy,
			r: req.second_radius};
		dx_c  = signed'({1'b0, b_c.x}) - signed'({1'b0, a_c.x});
		dy_c  = signed'({1'b0, b_c.y}) - signed'({1'b0, a_c.y});
		dvx_c = 25'(b_c.vx) - 25'(a_c.vx);
		dvy_c = 25'(b_c.vy) - 25'(a_c.vy);
		rs_c  = 16'(a_c.r) + 16'(b_c.r);
	end

	assign dxv_c = dx_s1 * dvx_s1;
	assign dyv_c = dy_s1 * dvy_s1;
	assign vxx_c = dvx_s1 * dvx_s1;
	assign vyy_c = dvy_s1 * dvy_s1;
	assign dxx_c = dx_s1 * dx_s1;
	assign dyy_c = dy_s1 * dy_s1;
	assign rr_c  = rs_s1 * rs_s1;

	always_comb begin
		g_c.dvdr = DVDR_W'(dxv_s2) + DVDR_W'(dyv_s2);
		g_c.dvdv = unsigned'(vxx_s2) + unsigned'(vyy_s2);
		g_c.drdr = dxx_s2[DRDR_W-1:0] + dyy_s2[DRDR_W-1:0];
		g_c.sig2 = rr_s2;
		g_c.p1   = p1_s2;
		g_c.p2   = p2_s2;
		// drop pairs that are the same disc, separating, or without relative motion
		g_c.kill = same_s2 || (!g_c.dvdr[DVDR_W-1] && g_c.dvdr != '0) || g_c.dvdv == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			same_s1 <= req.same_particle;
			p1_s1   <= a_c;
			p2_s1   <= b_c;
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			dvx_s1  <= dvx_c;
			dvy_s1  <= dvy_c;
			rs_s1   <= rs_c;

			same_s2 <= same_s1;
			p1_s2   <= p1_s1;
			p2_s2   <= p2_s1;
			dxv_s2  <= dxv_c;
			dyv_s2  <= dyv_c;
			vxx_s2  <= vxx_c;
			vyy_s2  <= vyy_c;
			dxx_s2  <= dxx_c;
			dyy_s2  <= dyy_c;
			rr_s2   <= rr_c;

			g_s3    <= g_c;
		end
	end

endmodule
`default_nettype wire

// File: sv/ppct_fifo.sv
`default_nettype none
module ppct_fifo import ppct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  geom_t push_data,
	input  logic  push_valid,
	output logic  push_ready,
	output geom_t pop_data,
	output logic  pop_valid,
	input  logic  pop_ready
);

	geom_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q, rd_q;
	logic [FIFO_AW:0]     cnt_q;
	logic                 push, pop;

	assign push_ready = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

// File: sv/ppct_back.sv
`default_nettype none
module ppct_back import ppct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  geom_t pop_data,
	input  logic  pop_valid,
	output logic  pop_ready,
	ppct_out_if.source rsp
);

	function automatic logic in_box(input logic [15:0] p, input logic [14:0] r,
		input logic signed [55:0] pr);
		logic signed [57:0] pos, lo, hi;
		pos = signed'({26'b0, p, 16'b0}) + 58'(pr);
		lo  = signed'({27'b0, r, 16'b0});
		hi  = signed'({25'b0, 17'(17'h1_0000 - {2'b0, r}), 16'b0});
		return pos >= lo && pos <= hi;
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [ROOT_W-1:0] sq_v_q;
	logic [QUO_W-1:0]  dv_v_q;

	// operand prep
	logic signed [DVDR_W-1:0] ndv_c;
	logic signed [DRDR_W:0]   dd_c;
	ctx_t              c1_c;
	ctx_t              c_s1;
	logic              ge_s1;
	logic [DRDR_W-1:0] dabs_s1;

	// partial products
	logic [41:0] hh_c, hl_c, ll_c, b11_c, b10_c, b01_c, b00_c;
	ctx_t        c_s2;
	logic        ge_s2;
	logic [41:0] hh_s2, hl_s2, ll_s2, b11_s2, b10_s2, b01_s2, b00_s2;

	ctx_t              c_s3;
	logic              ge_s3;
	logic [DISC_W-1:0] sq_s3, bb_s3;

	ctx_t              c4_c;
	ctx_t              c_s4;
	logic [DISC_W-1:0] disc_s4;

	// square root, one result bit per stage
	ctx_t              sq_c_q    [ROOT_W];
	logic [DISC_W-1:0] sq_d_q    [ROOT_W];
	logic [REM_W-1:0]  sq_r_q    [ROOT_W];
	logic [ROOT_W-1:0] sq_root_q [ROOT_W];
	logic [REM_W-1:0]  sq_r_n    [ROOT_W];
	logic [ROOT_W-1:0] sq_root_n [ROOT_W];

	logic signed [NEG_W+1:0] num_c;
	logic [NEG_W:0]          mag_c;
	logic [M_W-1:0]          m_c;
	ctx_t           c_s5;
	logic           sgn_s5, ovf_s5;
	logic [M_W-1:0] m_s5;

	// divider, one quotient bit per stage
	ctx_t              dv_c_q [QUO_W];
	logic [QUO_W-1:0]  dv_m_q [QUO_W];
	logic [DREM_W-1:0] dv_r_q [QUO_W];
	logic [QUO_W-1:0]  dv_q_q [QUO_W];
	logic              dv_s_q [QUO_W];
	logic              dv_o_q [QUO_W];
	logic [DREM_W-1:0] dv_r_n [QUO_W];
	logic [QUO_W-1:0]  dv_q_n [QUO_W];

	logic [QUO_W:0]     qc_c;
	logic signed [31:0] t_c;
	ctx_t               c_s6;
	logic signed [31:0] t_s6;

	logic signed [55:0] px1_c, py1_c, px2_c, py2_c;
	ctx_t               c_s7;
	logic signed [31:0] t_s7;
	logic signed [55:0] px1_s7, py1_s7, px2_s7, py2_s7;

	logic               hit_c;
	logic               hit_s8;
	logic signed [31:0] t_s8;

	assign adv       = !v_s8 || rsp.ready;
	assign pop_ready = adv;

	always_comb begin
		ndv_c     = -pop_data.dvdr;
		dd_c      = signed'({1'b0, pop_data.drdr}) - signed'({2'b0, pop_data.sig2});
		c1_c.kill = pop_data.kill;
		c1_c.neg  = ndv_c[NEG_W-1:0];
		c1_c.dvdv = pop_data.dvdv;
		c1_c.p1   = pop_data.p1;
		c1_c.p2   = pop_data.p2;
	end

	assign hh_c  = c_s1.neg[41:21] * c_s1.neg[41:21];
	assign hl_c  = c_s1.neg[41:21] * c_s1.neg[20:0];
	assign ll_c  = c_s1.neg[20:0] * c_s1.neg[20:0];
	assign b11_c = c_s1.dvdv[49:25] * dabs_s1[32:16];
	assign b10_c = c_s1.dvdv[49:25] * dabs_s1[15:0];
	assign b01_c = c_s1.dvdv[24:0] * dabs_s1[32:16];
	assign b00_c = c_s1.dvdv[24:0] * dabs_s1[15:0];

	// negative discriminant: no contact
	always_comb begin
		c4_c      = c_s3;
		c4_c.kill = c_s3.kill || (ge_s3 && sq_s3 < bb_s3);
	end

	always_comb begin
		logic [REM_W-1:0]  rin, cur, trial;
		logic [ROOT_W-1:0] oin;
		logic [DISC_W-1:0] din;
		for (int k = 0; k < ROOT_W; k++) begin
			rin   = (k == 0) ? '0 : sq_r_q[k == 0 ? 0 : k-1];
			oin   = (k == 0) ? '0 : sq_root_q[k == 0 ? 0 : k-1];
			din   = (k == 0) ? disc_s4 : sq_d_q[k == 0 ? 0 : k-1];
			cur   = {rin[REM_W-3:0], din[2*(ROOT_W-1-k) +: 2]};
			trial = {1'b0, oin, 2'b01};
			if (cur >= trial) begin
				sq_r_n[k]    = cur - trial;
				sq_root_n[k] = {oin[ROOT_W-2:0], 1'b1};
			end else begin
				sq_r_n[k]    = cur;
				sq_root_n[k] = {oin[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		num_c = signed'({2'b0, sq_c_q[ROOT_W-1].neg}) - signed'({1'b0, sq_root_q[ROOT_W-1]});
		mag_c = num_c[NEG_W+1] ? (NEG_W+1)'(-num_c) : num_c[NEG_W:0];
		m_c   = {mag_c, FRAC_BITS'(0)};
	end

	always_comb begin
		logic [DREM_W-1:0] rin, cur, dvs;
		logic [QUO_W-1:0]  qin, min;
		for (int j = 0; j < QUO_W; j++) begin
			rin = (j == 0) ? DREM_W'(m_s5[M_W-1:QUO_W]) : dv_r_q[j == 0 ? 0 : j-1];
			qin = (j == 0) ? '0 : dv_q_q[j == 0 ? 0 : j-1];
			min = (j == 0) ? m_s5[QUO_W-1:0] : dv_m_q[j == 0 ? 0 : j-1];
			dvs = (j == 0) ? {1'b0, c_s5.dvdv} : {1'b0, dv_c_q[j == 0 ? 0 : j-1].dvdv};
			cur = {rin[DREM_W-2:0], min[QUO_W-1-j]};
			if (cur >= dvs) begin
				dv_r_n[j] = cur - dvs;
				dv_q_n[j] = {qin[QUO_W-2:0], 1'b1};
			end else begin
				dv_r_n[j] = cur;
				dv_q_n[j] = {qin[QUO_W-2:0], 1'b0};
			end
		end
	end

	// saturate; negative quotients round toward minus infinity
	always_comb begin
		qc_c = (QUO_W+1)'(dv_q_q[QUO_W-1]) + (QUO_W+1)'(dv_r_q[QUO_W-1] != '0);
		if (!dv_s_q[QUO_W-1]) begin
			if (dv_o_q[QUO_W-1] || dv_q_q[QUO_W-1][QUO_W-1] || dv_q_q[QUO_W-1][QUO_W-2])
				t_c = T_MAX;
			else
				t_c = signed'(dv_q_q[QUO_W-1][31:0]);
		end else begin
			if (dv_o_q[QUO_W-1] || qc_c > (QUO_W+1)'(34'h0_8000_0000))
				t_c = T_MIN;
			else
				t_c = signed'(32'(-qc_c));
		end
	end

	assign px1_c = t_s6 * c_s6.p1.vx;
	assign py1_c = t_s6 * c_s6.p1.vy;
	assign px2_c = t_s6 * c_s6.p2.vx;
	assign py2_c = t_s6 * c_s6.p2.vy;

	assign hit_c = !c_s7.kill
		&& in_box(c_s7.p1.x, c_s7.p1.r, px1_s7) && in_box(c_s7.p1.y, c_s7.p1.r, py1_s7)
		&& in_box(c_s7.p2.x, c_s7.p2.r, px2_s7) && in_box(c_s7.p2.y, c_s7.p2.r, py2_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			sq_v_q <= '0;
			v_s5   <= 1'b0;
			dv_v_q <= '0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
		end else if (adv) begin
			v_s1   <= pop_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			sq_v_q <= {sq_v_q[ROOT_W-2:0], v_s4};
			v_s5   <= sq_v_q[ROOT_W-1];
			dv_v_q <= {dv_v_q[QUO_W-2:0], v_s5};
			v_s6   <= dv_v_q[QUO_W-1];
			v_s7   <= v_s6;
			v_s8   <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1    <= c1_c;
			ge_s1   <= !dd_c[DRDR_W];
			dabs_s1 <= dd_c[DRDR_W] ? DRDR_W'(-dd_c) : dd_c[DRDR_W-1:0];

			c_s2    <= c_s1;
			ge_s2   <= ge_s1;
			hh_s2   <= hh_c;
			hl_s2   <= hl_c;
			ll_s2   <= ll_c;
			b11_s2  <= b11_c;
			b10_s2  <= b10_c;
			b01_s2  <= b01_c;
			b00_s2  <= b00_c;

			c_s3    <= c_s2;
			ge_s3   <= ge_s2;
			sq_s3   <= (DISC_W'(hh_s2) << 42) + (DISC_W'(hl_s2) << 22) + DISC_W'(ll_s2);
			bb_s3   <= (DISC_W'(b11_s2) << 41) + (DISC_W'(b10_s2) << 25)
				+ (DISC_W'(b01_s2) << 16) + DISC_W'(b00_s2);

			c_s4      <= c4_c;
			disc_s4   <= ge_s3 ? sq_s3 - bb_s3 : sq_s3 + bb_s3;

			for (int k = 0; k < ROOT_W; k++) begin
				sq_c_q[k]    <= (k == 0) ? c_s4 : sq_c_q[k == 0 ? 0 : k-1];
				sq_d_q[k]    <= (k == 0) ? disc_s4 : sq_d_q[k == 0 ? 0 : k-1];
				sq_r_q[k]    <= sq_r_n[k];
				sq_root_q[k] <= sq_root_n[k];
			end

			c_s5   <= sq_c_q[ROOT_W-1];
			sgn_s5 <= num_c[NEG_W+1];
			ovf_s5 <= DVDV_W'(m_c[M_W-1:QUO_W]) >= sq_c_q[ROOT_W-1].dvdv;
			m_s5   <= m_c;

			for (int j = 0; j < QUO_W; j++) begin
				dv_c_q[j] <= (j == 0) ? c_s5 : dv_c_q[j == 0 ? 0 : j-1];
				dv_m_q[j] <= (j == 0) ? m_s5[QUO_W-1:0] : dv_m_q[j == 0 ? 0 : j-1];
				dv_s_q[j] <= (j == 0) ? sgn_s5 : dv_s_q[j == 0 ? 0 : j-1];
				dv_o_q[j] <= (j == 0) ? ovf_s5 : dv_o_q[j == 0 ? 0 : j-1];
				dv_r_q[j] <= dv_r_n[j];
				dv_q_q[j] <= dv_q_n[j];
			end

			c_s6   <= dv_c_q[QUO_W-1];
			t_s6   <= t_c;

			c_s7   <= c_s6;
			t_s7   <= t_s6;
			px1_s7 <= px1_c;
			py1_s7 <= py1_c;
			px2_s7 <= px2_c;
			py2_s7 <= py2_c;

			hit_s8 <= hit_c;
			t_s8   <= hit_c ? t_s7 : '0;
		end
	end

	assign rsp.valid           = v_s8;
	assign rsp.hit             = hit_s8;
	assign rsp.time_to_contact = t_s8;

endmodule
`default_nettype wire

// File: sv/particle_pair_collision_time_unit.sv
// Pair collision-time unit for two discs in the unit box.
// Channel req carries one disc pair per request: centres Q0.16, velocities
// signed Q8.16, radii Q0.16 and a same-disc flag. Channel rsp returns one
// response per request, in order: hit and a signed Q16.16 contact time,
// saturated, zero when there is no hit.
// Both channels transfer when valid and ready are high at a clock edge.
// Throughput is one request per cycle while no response waits with rsp.ready
// low and the queue has room. From acceptance a request passes 3 front stages,
// the queue, 4 stages forming the discriminant, 43 square-root stages (one
// root bit each), one stage for the numerator, 33 divider stages (one
// quotient bit each) and 3 stages for saturation and the box check before
// its response can be taken.
// The front stages fill a 4-entry queue; the back pipeline stalls as a
// whole while a response waits and rsp.ready is low, and the front keeps
// taking requests until the queue is full.
// arst_n clears all valid flags and the queue; no response is pending after
// reset.
`default_nettype none
module particle_pair_collision_time_unit import ppct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ppct_in_if.sink    req,
	ppct_out_if.source rsp
);

	geom_t push_data, pop_data;
	logic  push_valid, push_ready, pop_valid, pop_ready;

	ppct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	ppct_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	ppct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// File: sv/ppct_check.sv
`default_nettype none
module ppct_check (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_hit,
	input logic [31:0] rsp_time
);

	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_time == '0)
		else $error("no-hit response carries a nonzero time");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_time))
		else $error("stalled response changed or vanished");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("response valid after a reset cycle");

endmodule

bind particle_pair_collision_time_unit ppct_check u_ppct_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_hit   (rsp.hit),
	.rsp_time  (rsp.time_to_contact)
);
`default_nettype wire
